### hw/rtl/u8v_pkg.sv
// Shared types, constants and lookup functions for the UTF-8 string validator.
`default_nettype none

package u8v_pkg;

    localparam int MaxBuffer = 512;
    localparam int PosW      = 10;
    localparam int CountW    = 3;
    localparam int LenW      = 10;
    localparam int IndexW    = 2;

    localparam logic [PosW-1:0] LimitCap =
        PosW'((MaxBuffer > ((1 << PosW) - 1)) ? ((1 << PosW) - 1) : MaxBuffer);

    localparam logic [IndexW-1:0] CfgMinLength = 2'd0;
    localparam logic [IndexW-1:0] CfgMaxLength = 2'd1;

    localparam logic [LenW-1:0] MinLengthReset = 10'd4;
    localparam logic [LenW-1:0] MaxLengthReset = 10'd500;

    typedef enum logic [2:0] {
        StValid     = 3'd0,
        StTooShort  = 3'd1,
        StBadLead   = 3'd2,
        StBadCont   = 3'd3,
        StCtrlChar  = 3'd4,
        StTruncated = 3'd5,
        StNoTerm    = 3'd6
    } status_t;

    typedef struct packed {
        logic [PosW-1:0]   pos;
        logic [CountW-1:0] cont;
        logic              done;
    } scan_t;

    typedef struct packed {
        logic            fire;
        status_t         status;
        logic [PosW-1:0] pos;
    } verdict_t;

    function automatic logic [CountW-1:0] lead_count(input logic [5:0] low);
        logic [CountW-1:0] n;
        if (!low[5])
        begin
            n = 3'd1;
        end
        else if (!low[4])
        begin
            n = 3'd2;
        end
        else if (!low[3])
        begin
            n = 3'd3;
        end
        else if (!low[2])
        begin
            n = 3'd4;
        end
        else if (!low[1])
        begin
            n = 3'd5;
        end
        else
        begin
            n = 3'd0;
        end
        return n;
    endfunction

    function automatic logic ctrl_ok(input logic [4:0] code);
        return (code == 5'h09) || (code == 5'h0a) || (code == 5'h0d);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/u8v_check.sv
// Per-byte decision logic: next scan state and verdict for one input byte.
`default_nettype none

module u8v_check (
    input  wire u8v_pkg::scan_t              cur,
    input  wire                              first_byte,
    input  wire [7:0]                        data_byte,
    input  wire [u8v_pkg::LenW-1:0]          min_length,
    input  wire [u8v_pkg::PosW-1:0]          limit,
    output u8v_pkg::scan_t                   nxt,
    output u8v_pkg::verdict_t                vrd
);
    import u8v_pkg::*;

    logic [PosW-1:0]   p;
    logic [PosW-1:0]   p1;
    logic [CountW-1:0] n;
    logic              active;
    logic              advance;

    always_comb
    begin
        nxt        = cur;
        vrd.fire   = 1'b0;
        vrd.status = StValid;
        vrd.pos    = '0;
        advance    = 1'b0;
        n          = lead_count(data_byte[5:0]);
        p          = first_byte ? '0 : cur.pos;
        p1         = p + 1'b1;
        active     = first_byte || !cur.done;

        if (first_byte)
        begin
            nxt.pos  = '0;
            nxt.cont = '0;
            nxt.done = 1'b0;
        end

        if (active)
        begin
            vrd.pos = p;
            if (p >= limit)
            begin
                vrd.fire   = 1'b1;
                vrd.status = StNoTerm;
            end
            else if (!first_byte && cur.cont != '0)
            begin
                if (data_byte[7:6] != 2'b10)
                begin
                    vrd.fire   = 1'b1;
                    vrd.status = StBadCont;
                end
                else
                begin
                    nxt.cont = cur.cont - 1'b1;
                    advance  = 1'b1;
                end
            end
            else if (data_byte == 8'h00)
            begin
                vrd.fire   = 1'b1;
                vrd.status = (p >= min_length) ? StValid : StTooShort;
            end
            else if (data_byte[7])
            begin
                if (!data_byte[6] || n == '0)
                begin
                    vrd.fire   = 1'b1;
                    vrd.status = StBadLead;
                end
                else if (({1'b0, p} + {{(PosW + 1 - CountW){1'b0}}, n}) >= {1'b0, limit})
                begin
                    vrd.fire   = 1'b1;
                    vrd.status = StTruncated;
                end
                else
                begin
                    nxt.cont = n;
                    advance  = 1'b1;
                end
            end
            else if (data_byte[7:5] == 3'b000 && !ctrl_ok(data_byte[4:0]))
            begin
                vrd.fire   = 1'b1;
                vrd.status = StCtrlChar;
            end
            else
            begin
                advance = 1'b1;
            end

            if (advance)
            begin
                nxt.pos = p1;
                if (p1 >= limit)
                begin
                    vrd.fire   = 1'b1;
                    vrd.status = StNoTerm;
                    vrd.pos    = p1;
                end
            end

            if (vrd.fire)
            begin
                nxt.done = 1'b1;
                nxt.cont = '0;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/utf8_string_validator_core.sv
// Top level of the UTF-8 string validator: stream ports, registers, verdict output stage.
//
// Channel  Dir  Beat                 Payload
// s_*      in   s_tvalid & s_tready  tdata = data_byte, tuser = first_byte
// m_*      out  m_tvalid & m_tready  tdata = status, stop_position
// cfg_*    in   cfg_valid & cfg_ready index 0 min_length, 1 max_length
//
// One byte per cycle while s_tready is high; its verdict appears in the output register in the next cycle.
// The output register accepts a new byte while the last verdict is taken.
// A stalled verdict holds s_tready low until m_tready returns.
// Reset: scan idle until a byte with first_byte set, min_length 4, max_length 500.
`default_nettype none

module utf8_string_validator_core (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire [7:0]                      s_tdata,   // [7:0] data_byte
    input  wire                            s_tuser,   // [0] first_byte
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [15:0]                    m_tdata,   // [2:0] status, [12:3] stop_position, [15:13] zero
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire [u8v_pkg::IndexW-1:0]      cfg_index,
    input  wire [u8v_pkg::LenW-1:0]        cfg_data
);
    import u8v_pkg::*;

    logic [LenW-1:0] min_length_reg;
    logic [LenW-1:0] max_length_reg;
    logic [PosW-1:0] limit;
    scan_t           scan_reg;
    scan_t           scan_next;
    verdict_t        vrd;
    logic            out_valid_reg;
    status_t         status_reg;
    logic [PosW-1:0] stop_pos_reg;
    logic            take;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign take      = s_tvalid && s_tready;
    assign limit     = (max_length_reg < LimitCap) ? max_length_reg : LimitCap;

    u8v_check u_check (
        .cur        (scan_reg),
        .first_byte (s_tuser),
        .data_byte  (s_tdata),
        .min_length (min_length_reg),
        .limit      (limit),
        .nxt        (scan_next),
        .vrd        (vrd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= MinLengthReset;
            max_length_reg <= MaxLengthReset;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CfgMinLength: min_length_reg <= cfg_data;
                CfgMaxLength: max_length_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg      <= '{pos: '0, cont: '0, done: 1'b1};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                scan_reg      <= scan_next;
                out_valid_reg <= vrd.fire;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && vrd.fire)
        begin
            status_reg   <= vrd.status;
            stop_pos_reg <= vrd.pos;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, stop_pos_reg, status_reg};

endmodule

`default_nettype wire
